@@ rtl/core/rmq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg
// Types, widths and stage map shared by the rotation matrix to quaternion
// pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = DATA_WIDTH - 2;
   localparam int SUM_W      = DATA_WIDTH + 3;
   localparam int PAIR_W     = DATA_WIDTH + 1;
   localparam int MAG_W      = DATA_WIDTH + 1;
   localparam int RAD_W      = 2 * DATA_WIDTH - 2;
   localparam int ROOT_W     = DATA_WIDTH - 1;
   localparam int REM_W      = ROOT_W + 2;
   localparam int NUM_W      = 2 * DATA_WIDTH - 2;
   localparam int DEN_W      = DATA_WIDTH;
   localparam int QUO_W      = DATA_WIDTH;
   localparam int DREM_W     = DEN_W + 1;
   localparam int LANES      = 3;

   localparam int SQ_STEPS   = 5;
   localparam int SQ_STAGES  = (ROOT_W + SQ_STEPS - 1) / SQ_STEPS;
   localparam int DV_STEPS   = 4;
   localparam int DV_STAGES  = (QUO_W + DV_STEPS - 1) / DV_STEPS;

   localparam int ST_SUM     = 0;
   localparam int ST_PIV     = 1;
   localparam int ST_SQ0     = 2;
   localparam int ST_DVS     = ST_SQ0 + SQ_STAGES;
   localparam int ST_DV0     = ST_DVS + 1;
   localparam int ST_OUT     = ST_DV0 + DV_STAGES;
   localparam int NUM_STAGES = ST_OUT + 1;

   localparam logic [QUO_W-1:0] POS_LIMIT = QUO_W'((1 << (DATA_WIDTH - 1)) - 1);
   localparam logic [QUO_W-1:0] NEG_LIMIT = QUO_W'(1 << (DATA_WIDTH - 1));

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic [NUM_STAGES-1:0] stage_en_type;

   typedef enum logic [1:0] {
      PIV_X = 2'd0,
      PIV_Y = 2'd1,
      PIV_Z = 2'd2,
      PIV_W = 2'd3
   } pivot_type;

   typedef struct packed {
      data_type m00;
      data_type m01;
      data_type m02;
      data_type m10;
      data_type m11;
      data_type m12;
      data_type m20;
      data_type m21;
      data_type m22;
   } req_type;

   typedef struct packed {
      data_type   qx;
      data_type   qy;
      data_type   qz;
      data_type   qw;
      logic [1:0] pivot_index;
      logic       degenerate;
   } rsp_type;

   typedef struct packed {
      pivot_type                       pivot;
      logic                            degen;
      logic [LANES-1:0]                neg;
      logic [LANES-1:0][MAG_W-1:0]     mag;
   } side_type;

   typedef struct packed {
      logic [RAD_W-1:0] x;
      side_type         side;
   } sq_src_type;

   typedef struct packed {
      logic [ROOT_W-1:0] root;
      side_type          side;
   } dv_src_type;

   typedef struct packed {
      logic [LANES-1:0][QUO_W-1:0] quot;
      logic [LANES-1:0]            ovf;
      logic [ROOT_W-1:0]           root;
      side_type                    side;
   } dv_res_type;

   function automatic logic [1:0] lane_comp(input pivot_type piv, input logic [1:0] lane);
      logic [1:0] c;
      c = (lane >= piv) ? lane + 2'd1 : lane;
      return c;
   endfunction

endpackage

@@ rtl/core/rmq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_ctrl
// Stage valid bits and per-stage load enables with bubble collapse.
// ----------------------------------------------------------------------------
module rmq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  rsp_ready,
   output logic                  req_ready,
   output logic                  rsp_valid,
   output rmq_pkg::stage_en_type en
);

   logic [rmq_pkg::NUM_STAGES-1:0] valid_ff;
   logic [rmq_pkg::NUM_STAGES-1:0] valid_in;

   assign valid_in = {valid_ff[rmq_pkg::NUM_STAGES-2:0], req_valid};

   always_comb begin
      en[rmq_pkg::NUM_STAGES-1] = !valid_ff[rmq_pkg::NUM_STAGES-1] | rsp_ready;
      for (int k = rmq_pkg::NUM_STAGES - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] | en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < rmq_pkg::NUM_STAGES; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = valid_ff[rmq_pkg::NUM_STAGES-1];

endmodule

@@ rtl/core/rmq_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_front
// Diagonal sums, pivot pick, radicand and pair numerators (two stages).
// ----------------------------------------------------------------------------
module rmq_front (
   input  logic                  clock,
   input  rmq_pkg::stage_en_type en,
   input  rmq_pkg::req_type      req_data,
   output rmq_pkg::sq_src_type   sq_src
);

   typedef logic signed [rmq_pkg::SUM_W-1:0]  sum_type;
   typedef logic signed [rmq_pkg::PAIR_W-1:0] pair_type;

   sum_type  s_ff [4];
   sum_type  s_in [4];
   pair_type sxy_ff, sxz_ff, syz_ff, dx_ff, dy_ff, dz_ff;
   pair_type sxy_in, sxz_in, syz_in, dx_in, dy_in, dz_in;
   rmq_pkg::sq_src_type sq_ff, sq_in;

   always_comb begin
      sum_type a, b, c, one;
      a   = rmq_pkg::SUM_W'(req_data.m00);
      b   = rmq_pkg::SUM_W'(req_data.m11);
      c   = rmq_pkg::SUM_W'(req_data.m22);
      one = rmq_pkg::SUM_W'(1 << rmq_pkg::FRAC_BITS);
      s_in[0] = a - b - c + one;
      s_in[1] = b - a - c + one;
      s_in[2] = c - a - b + one;
      s_in[3] = a + b + c + one;
      sxy_in = rmq_pkg::PAIR_W'(req_data.m10) + rmq_pkg::PAIR_W'(req_data.m01);
      sxz_in = rmq_pkg::PAIR_W'(req_data.m02) + rmq_pkg::PAIR_W'(req_data.m20);
      syz_in = rmq_pkg::PAIR_W'(req_data.m21) + rmq_pkg::PAIR_W'(req_data.m12);
      dx_in  = rmq_pkg::PAIR_W'(req_data.m21) - rmq_pkg::PAIR_W'(req_data.m12);
      dy_in  = rmq_pkg::PAIR_W'(req_data.m02) - rmq_pkg::PAIR_W'(req_data.m20);
      dz_in  = rmq_pkg::PAIR_W'(req_data.m10) - rmq_pkg::PAIR_W'(req_data.m01);
   end

   always_ff @(posedge clock) begin
      if (en[rmq_pkg::ST_SUM]) begin
         s_ff   <= s_in;
         sxy_ff <= sxy_in;
         sxz_ff <= sxz_in;
         syz_ff <= syz_in;
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         dz_ff  <= dz_in;
      end
   end

   always_comb begin
      sum_type            best;
      rmq_pkg::pivot_type piv;
      pair_type           num [rmq_pkg::LANES];
      best = s_ff[0];
      piv  = rmq_pkg::PIV_X;
      if (s_ff[1] > best) begin
         best = s_ff[1];
         piv  = rmq_pkg::PIV_Y;
      end
      if (s_ff[2] > best) begin
         best = s_ff[2];
         piv  = rmq_pkg::PIV_Z;
      end
      if (s_ff[3] > best) begin
         best = s_ff[3];
         piv  = rmq_pkg::PIV_W;
      end
      unique case (piv)
         rmq_pkg::PIV_X: begin
            num[0] = sxy_ff; num[1] = sxz_ff; num[2] = dx_ff;
         end
         rmq_pkg::PIV_Y: begin
            num[0] = sxy_ff; num[1] = syz_ff; num[2] = dy_ff;
         end
         rmq_pkg::PIV_Z: begin
            num[0] = sxz_ff; num[1] = syz_ff; num[2] = dz_ff;
         end
         default: begin
            num[0] = dx_ff; num[1] = dy_ff; num[2] = dz_ff;
         end
      endcase
      sq_in.side.pivot = piv;
      sq_in.side.degen = (best <= 0);
      for (int j = 0; j < rmq_pkg::LANES; j++) begin
         sq_in.side.neg[j] = num[j][rmq_pkg::PAIR_W-1];
         sq_in.side.mag[j] = rmq_pkg::MAG_W'(num[j][rmq_pkg::PAIR_W-1] ? -num[j] : num[j]);
      end
      if (best <= 0) begin
         sq_in.x = '0;
      end else begin
         sq_in.x = rmq_pkg::RAD_W'(best[rmq_pkg::DATA_WIDTH:0]) << (rmq_pkg::FRAC_BITS - 2);
      end
   end

   always_ff @(posedge clock) begin
      if (en[rmq_pkg::ST_PIV]) begin
         sq_ff <= sq_in;
      end
   end

   assign sq_src = sq_ff;

endmodule

@@ rtl/core/rmq_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined digit-by-digit integer square root of the pivot radicand.
// ----------------------------------------------------------------------------
module rmq_sqrt (
   input  logic                  clock,
   input  rmq_pkg::stage_en_type en,
   input  rmq_pkg::sq_src_type   sq_src,
   output rmq_pkg::dv_src_type   dv_src
);

   typedef struct packed {
      logic [rmq_pkg::REM_W-1:0]  rem;
      logic [rmq_pkg::ROOT_W-1:0] root;
      logic [rmq_pkg::RAD_W-1:0]  x;
      rmq_pkg::side_type          side;
   } sq_stage_type;

   sq_stage_type st_ff [rmq_pkg::SQ_STAGES];
   sq_stage_type st_in [rmq_pkg::SQ_STAGES];
   sq_stage_type head;

   always_comb begin
      head.rem  = '0;
      head.root = '0;
      head.x    = sq_src.x;
      head.side = sq_src.side;
   end

   for (genvar s = 0; s < rmq_pkg::SQ_STAGES; s++) begin : g_stage
      sq_stage_type prev;
      if (s == 0) begin : g_first
         assign prev = head;
      end else begin : g_next
         assign prev = st_ff[s-1];
      end

      always_comb begin
         sq_stage_type               cur;
         logic [rmq_pkg::REM_W-1:0]  rt;
         logic [rmq_pkg::REM_W-1:0]  trial;
         int                         idx;
         int                         b;
         cur = prev;
         for (int k = 0; k < rmq_pkg::SQ_STEPS; k++) begin
            idx = s * rmq_pkg::SQ_STEPS + k;
            if (idx < rmq_pkg::ROOT_W) begin
               b     = rmq_pkg::ROOT_W - 1 - idx;
               rt    = {cur.rem[rmq_pkg::REM_W-3:0], cur.x[2*b +: 2]};
               trial = {cur.root, 2'b01};
               if (rt >= trial) begin
                  cur.rem  = rt - trial;
                  cur.root = {cur.root[rmq_pkg::ROOT_W-2:0], 1'b1};
               end else begin
                  cur.rem  = rt;
                  cur.root = {cur.root[rmq_pkg::ROOT_W-2:0], 1'b0};
               end
            end
         end
         st_in[s] = cur;
      end

      always_ff @(posedge clock) begin
         if (en[rmq_pkg::ST_SQ0 + s]) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   assign dv_src.root = st_ff[rmq_pkg::SQ_STAGES-1].root;
   assign dv_src.side = st_ff[rmq_pkg::SQ_STAGES-1].side;

endmodule

@@ rtl/core/rmq_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_div
// Three-lane pipelined restoring divider for the off-pivot components.
// ----------------------------------------------------------------------------
module rmq_div (
   input  logic                  clock,
   input  rmq_pkg::stage_en_type en,
   input  rmq_pkg::dv_src_type   dv_src,
   output rmq_pkg::dv_res_type   dv_res
);

   localparam int LANES = rmq_pkg::LANES;

   typedef struct packed {
      logic [LANES-1:0][rmq_pkg::DREM_W-1:0] rem;
      logic [LANES-1:0][rmq_pkg::DEN_W-1:0]  low;
      logic [LANES-1:0][rmq_pkg::QUO_W-1:0]  quot;
      logic [LANES-1:0]                      ovf;
      logic [rmq_pkg::DEN_W-1:0]             den;
      logic [rmq_pkg::ROOT_W-1:0]            root;
      rmq_pkg::side_type                     side;
   } dv_stage_type;

   dv_stage_type setup_ff, setup_in;
   dv_stage_type st_ff [rmq_pkg::DV_STAGES];
   dv_stage_type st_in [rmq_pkg::DV_STAGES];

   always_comb begin
      logic [rmq_pkg::NUM_W-1:0]         n;
      logic [rmq_pkg::DEN_W-1:0]         d;
      logic [2*rmq_pkg::DEN_W-1:0]       lim;
      d   = {dv_src.root, 1'b0};
      lim = {d, rmq_pkg::DEN_W'(0)};
      setup_in.den  = d;
      setup_in.root = dv_src.root;
      setup_in.side = dv_src.side;
      setup_in.quot = '0;
      for (int j = 0; j < LANES; j++) begin
         n = (rmq_pkg::NUM_W'(dv_src.side.mag[j]) << (rmq_pkg::FRAC_BITS - 1))
             + rmq_pkg::NUM_W'(dv_src.root);
         setup_in.ovf[j] = ((2 * rmq_pkg::DEN_W)'(n) >= lim);
         setup_in.rem[j] = rmq_pkg::DREM_W'(n[rmq_pkg::NUM_W-1:rmq_pkg::DEN_W]);
         setup_in.low[j] = n[rmq_pkg::DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[rmq_pkg::ST_DVS]) begin
         setup_ff <= setup_in;
      end
   end

   for (genvar s = 0; s < rmq_pkg::DV_STAGES; s++) begin : g_stage
      dv_stage_type prev;
      if (s == 0) begin : g_first
         assign prev = setup_ff;
      end else begin : g_next
         assign prev = st_ff[s-1];
      end

      always_comb begin
         dv_stage_type               cur;
         logic [rmq_pkg::DREM_W-1:0] rt;
         int                         idx;
         int                         b;
         cur = prev;
         for (int k = 0; k < rmq_pkg::DV_STEPS; k++) begin
            idx = s * rmq_pkg::DV_STEPS + k;
            if (idx < rmq_pkg::QUO_W) begin
               b = rmq_pkg::QUO_W - 1 - idx;
               for (int j = 0; j < LANES; j++) begin
                  rt = {cur.rem[j][rmq_pkg::DREM_W-2:0], cur.low[j][b]};
                  if (rt >= {1'b0, cur.den}) begin
                     cur.rem[j]     = rt - {1'b0, cur.den};
                     cur.quot[j][b] = 1'b1;
                  end else begin
                     cur.rem[j]     = rt;
                     cur.quot[j][b] = 1'b0;
                  end
               end
            end
         end
         st_in[s] = cur;
      end

      always_ff @(posedge clock) begin
         if (en[rmq_pkg::ST_DV0 + s]) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   assign dv_res.quot = st_ff[rmq_pkg::DV_STAGES-1].quot;
   assign dv_res.ovf  = st_ff[rmq_pkg::DV_STAGES-1].ovf;
   assign dv_res.root = st_ff[rmq_pkg::DV_STAGES-1].root;
   assign dv_res.side = st_ff[rmq_pkg::DV_STAGES-1].side;

endmodule

@@ rtl/core/rotation_matrix_to_quaternion_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// Rotation matrix to quaternion converter, signed Q1.14 in and out.
// ----------------------------------------------------------------------------
// Usage: present the nine matrix elements on req_data with req_valid; an
// item is taken on an edge where req_valid and req_ready are both high. The
// quaternion, pivot index and degenerate flag come back on rsp_data with
// rsp_valid and are taken when rsp_ready is high.
// Pipeline: eleven register stages (two front stages, three square root
// stages, one divider setup, four divider stages, one output register);
// rsp_valid is the valid bit of the output register. Throughput: one item
// per cycle while rsp_ready is high; the square root and the divider are
// fully unrolled pipelines, so each stage holds its own item.
// Stall: when rsp_ready is low the output register holds its item; earlier
// stages keep filling empty slots, and req_ready falls only once every
// stage holds an item. No item is lost or repeated.
// Reset: clears all stage valid bits; the pipeline is empty and req_ready
// is high in the first cycle after reset.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rmq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rmq_pkg::rsp_type rsp_data
);

   rmq_pkg::stage_en_type en;
   rmq_pkg::sq_src_type   sq_src;
   rmq_pkg::dv_src_type   dv_src;
   rmq_pkg::dv_res_type   dv_res;
   rmq_pkg::rsp_type      rsp_ff, rsp_in;

   rmq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_ready (rsp_ready),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .en        (en)
   );

   rmq_front u_front (
      .clock    (clock),
      .en       (en),
      .req_data (req_data),
      .sq_src   (sq_src)
   );

   rmq_sqrt u_sqrt (
      .clock  (clock),
      .en     (en),
      .sq_src (sq_src),
      .dv_src (dv_src)
   );

   rmq_div u_div (
      .clock  (clock),
      .en     (en),
      .dv_src (dv_src),
      .dv_res (dv_res)
   );

   always_comb begin
      rmq_pkg::data_type          q [4];
      rmq_pkg::data_type          v;
      logic [1:0]                 c;
      logic [rmq_pkg::QUO_W-1:0]  mag;
      for (int i = 0; i < 4; i++) begin
         q[i] = '0;
      end
      q[dv_res.side.pivot] = rmq_pkg::DATA_WIDTH'(dv_res.root);
      for (int j = 0; j < rmq_pkg::LANES; j++) begin
         c   = rmq_pkg::lane_comp(dv_res.side.pivot, 2'(j));
         mag = dv_res.quot[j];
         if (dv_res.side.neg[j]) begin
            if (dv_res.ovf[j] || mag > rmq_pkg::NEG_LIMIT) begin
               v = rmq_pkg::data_type'(rmq_pkg::NEG_LIMIT);
            end else begin
               v = rmq_pkg::data_type'(-mag);
            end
         end else begin
            if (dv_res.ovf[j] || mag > rmq_pkg::POS_LIMIT) begin
               v = rmq_pkg::data_type'(rmq_pkg::POS_LIMIT);
            end else begin
               v = rmq_pkg::data_type'(mag);
            end
         end
         q[c] = v;
      end
      if (dv_res.side.degen) begin
         for (int i = 0; i < 4; i++) begin
            q[i] = '0;
         end
      end
      rsp_in.qx          = q[0];
      rsp_in.qy          = q[1];
      rsp_in.qz          = q[2];
      rsp_in.qw          = q[3];
      rsp_in.pivot_index = dv_res.side.pivot;
      rsp_in.degenerate  = dv_res.side.degen;
   end

   always_ff @(posedge clock) begin
      if (en[rmq_pkg::ST_OUT]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.qx == '0 && rsp_data.qy == '0 && rsp_data.qz == '0 && rsp_data.qw == '0)
      else $error("degenerate item with nonzero quaternion");

   a_pivot_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.degenerate |->
         !((rsp_data.pivot_index == rmq_pkg::PIV_X && rsp_data.qx[rmq_pkg::DATA_WIDTH-1]) ||
           (rsp_data.pivot_index == rmq_pkg::PIV_Y && rsp_data.qy[rmq_pkg::DATA_WIDTH-1]) ||
           (rsp_data.pivot_index == rmq_pkg::PIV_Z && rsp_data.qz[rmq_pkg::DATA_WIDTH-1]) ||
           (rsp_data.pivot_index == rmq_pkg::PIV_W && rsp_data.qw[rmq_pkg::DATA_WIDTH-1])))
      else $error("pivot component negative");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output stage");

endmodule

@@ bench/rotation_matrix_to_quaternion_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_checker
// Watches both channels, predicts each quaternion from the accepted matrix
// and compares every result field by field, in order.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  rmq_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  rmq_pkg::rsp_type rsp_data,
   output int               error_count,
   output int               pending_count
);

   localparam longint SAT_HI = (64'sd1 <<< (rmq_pkg::DATA_WIDTH - 1)) - 1;
   localparam longint SAT_LO = -SAT_HI - 1;

   rmq_pkg::rsp_type expected_quats[$];

   function automatic longint clamp_q(input longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
   endfunction

   function automatic longint int_root(input longint x);
      longint r;
      longint b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > x) b = b >>> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   function automatic longint pair_ratio(input longint n, input longint root);
      longint mag;
      longint d;
      longint qq;
      mag = (n < 0) ? -n : n;
      d = root * 4;
      qq = ((mag <<< rmq_pkg::FRAC_BITS) * 2 + d) / (d * 2);
      return clamp_q((n < 0) ? -qq : qq);
   endfunction

   function automatic rmq_pkg::rsp_type quat_of(input rmq_pkg::req_type m);
      longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
      longint one, root;
      longint diag [4];
      longint num [4][4];
      longint comp [4];
      int piv;
      rmq_pkg::rsp_type r;
      a00 = m.m00; a01 = m.m01; a02 = m.m02;
      a10 = m.m10; a11 = m.m11; a12 = m.m12;
      a20 = m.m20; a21 = m.m21; a22 = m.m22;
      one = 64'sd1 <<< rmq_pkg::FRAC_BITS;
      diag[0] = a00 - a11 - a22 + one;
      diag[1] = -a00 + a11 - a22 + one;
      diag[2] = -a00 - a11 + a22 + one;
      diag[3] = a00 + a11 + a22 + one;
      piv = 0;
      for (int i = 1; i < 4; i++) if (diag[i] > diag[piv]) piv = i;
      num[0][1] = a10 + a01; num[0][2] = a02 + a20; num[0][3] = a21 - a12;
      num[1][0] = a10 + a01; num[1][2] = a21 + a12; num[1][3] = a02 - a20;
      num[2][0] = a02 + a20; num[2][1] = a21 + a12; num[2][3] = a10 - a01;
      num[3][0] = a21 - a12; num[3][1] = a02 - a20; num[3][2] = a10 - a01;
      for (int i = 0; i < 4; i++) comp[i] = 0;
      r.degenerate = (diag[piv] <= 0);
      if (!r.degenerate) begin
         root = int_root(diag[piv] <<< (rmq_pkg::FRAC_BITS - 2));
         for (int i = 0; i < 4; i++)
            comp[i] = (i == piv) ? clamp_q(root) : pair_ratio(num[piv][i], root);
      end
      r.qx = rmq_pkg::data_type'(comp[0]);
      r.qy = rmq_pkg::data_type'(comp[1]);
      r.qz = rmq_pkg::data_type'(comp[2]);
      r.qw = rmq_pkg::data_type'(comp[3]);
      r.pivot_index = 2'(piv);
      return r;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      rmq_pkg::rsp_type want;
      if (reset) begin
         error_count = 0;
         pending_count = 0;
      end else begin
         if (req_valid && req_ready) expected_quats.push_back(quat_of(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_quats.size() == 0) begin
               report("unexpected item", 1, 0);
            end else begin
               want = expected_quats.pop_front();
               if (rsp_data.qx !== want.qx) report("qx", rsp_data.qx, want.qx);
               if (rsp_data.qy !== want.qy) report("qy", rsp_data.qy, want.qy);
               if (rsp_data.qz !== want.qz) report("qz", rsp_data.qz, want.qz);
               if (rsp_data.qw !== want.qw) report("qw", rsp_data.qw, want.qw);
               if (rsp_data.pivot_index !== want.pivot_index)
                  report("pivot_index", rsp_data.pivot_index, want.pivot_index);
               if (rsp_data.degenerate !== want.degenerate)
                  report("degenerate", rsp_data.degenerate, want.degenerate);
            end
         end
         pending_count = expected_quats.size();
      end
   end
endmodule

@@ bench/rotation_matrix_to_quaternion_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top_test
// Drives directed and random matrices with random gaps and stalls, including
// a long output hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top_test;

   localparam int RANDOM_ITEMS = 800;
   localparam longint CYCLE_LIMIT = 200000;
   localparam logic signed [15:0] ONE = 16'sd16384;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_ready;
   rmq_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 0;
   rmq_pkg::rsp_type rsp_data;
   int               error_count;
   int               pending_count;
   longint           cycle_count = 0;
   bit               hold_off = 0;
   bit               rsp_took = 0;
   int               rsp_wait = 0;

   always #6 clock = ~clock;

   rotation_matrix_to_quaternion_top i_dut (.*);

   rotation_matrix_to_quaternion_checker i_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_matrix(input rmq_pkg::req_type m);
      int gap;
      gap = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_data <= m;
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   function automatic rmq_pkg::data_type rand_elem();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return rmq_pkg::data_type'($urandom_range(0, 65535));
         default: return rmq_pkg::data_type'($signed(17'($urandom_range(0, 32768)))
                                             - 17'sd16384);
      endcase
   endfunction

   function automatic rmq_pkg::req_type diag_matrix(input rmq_pkg::data_type a,
                                                    input rmq_pkg::data_type b,
                                                    input rmq_pkg::data_type c);
      rmq_pkg::req_type m;
      m = '0;
      m.m00 = a; m.m11 = b; m.m22 = c;
      return m;
   endfunction

   function automatic rmq_pkg::req_type rotation_like();
      rmq_pkg::req_type m;
      real ax, ay, az, ang, n, c, s, t;
      ax = $urandom_range(0, 2000) - 1000.0;
      ay = $urandom_range(0, 2000) - 1000.0;
      az = $urandom_range(0, 2000) - 1000.0;
      n = $sqrt(ax * ax + ay * ay + az * az) + 1e-9;
      ax = ax / n; ay = ay / n; az = az / n;
      ang = $urandom_range(0, 6283) / 1000.0;
      c = $cos(ang); s = $sin(ang); t = 1.0 - c;
      m.m00 = rmq_pkg::data_type'($rtoi((t * ax * ax + c) * 16383.0));
      m.m01 = rmq_pkg::data_type'($rtoi((t * ax * ay - s * az) * 16383.0));
      m.m02 = rmq_pkg::data_type'($rtoi((t * ax * az + s * ay) * 16383.0));
      m.m10 = rmq_pkg::data_type'($rtoi((t * ax * ay + s * az) * 16383.0));
      m.m11 = rmq_pkg::data_type'($rtoi((t * ay * ay + c) * 16383.0));
      m.m12 = rmq_pkg::data_type'($rtoi((t * ay * az - s * ax) * 16383.0));
      m.m20 = rmq_pkg::data_type'($rtoi((t * ax * az - s * ay) * 16383.0));
      m.m21 = rmq_pkg::data_type'($rtoi((t * ay * az + s * ax) * 16383.0));
      m.m22 = rmq_pkg::data_type'($rtoi((t * az * az + c) * 16383.0));
      return m;
   endfunction

   always @(posedge clock) begin
      rsp_took <= rsp_valid && rsp_ready;
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_took) rsp_wait = $urandom_range(0, 11);
         if (hold_off) begin
            rsp_ready <= 0;
         end else if (rsp_wait != 0) begin
            rsp_wait = rsp_wait - 1;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   initial begin
      hold_off = 0;
      wait (!reset);
      repeat (150) @(negedge clock);
      hold_off = 1;
      repeat (60) @(negedge clock);
      hold_off = 0;
   end

   initial begin
      rmq_pkg::req_type m;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      send_matrix(diag_matrix(ONE, ONE, ONE));
      send_matrix(diag_matrix(ONE, -ONE, -ONE));
      send_matrix(diag_matrix(-ONE, ONE, -ONE));
      send_matrix(diag_matrix(-ONE, -ONE, ONE));
      send_matrix(diag_matrix(16'sh8000, 16'sh8000, 16'sh8000));
      send_matrix(diag_matrix(16'sh7fff, 16'sh7fff, 16'sh7fff));
      send_matrix(diag_matrix(16'sh8000, 16'sh7fff, 16'sh7fff));
      send_matrix(diag_matrix(-ONE, -ONE, -ONE));
      send_matrix(diag_matrix(16'sd0, 16'sd0, 16'sd0));
      send_matrix(diag_matrix(-16'sd5461, -16'sd5461, -16'sd5461));
      send_matrix('1);
      send_matrix({9{16'sh8000}});
      send_matrix({9{16'sh7fff}});
      m = diag_matrix(16'sd1, 16'sd1, -16'sd16386);
      m.m01 = 16'sh7fff; m.m10 = 16'sh7fff; m.m02 = 16'sh8000; m.m20 = 16'sh8000;
      m.m12 = 16'sh7fff; m.m21 = 16'sh8000;
      send_matrix(m);
      m = diag_matrix(-ONE, -ONE, -ONE);
      m.m01 = 16'sh7fff; m.m10 = 16'sh8000; m.m12 = 16'sh8000; m.m21 = 16'sh7fff;
      send_matrix(m);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 3) != 0) begin
            m = rotation_like();
         end else begin
            m.m00 = rand_elem(); m.m01 = rand_elem(); m.m02 = rand_elem();
            m.m10 = rand_elem(); m.m11 = rand_elem(); m.m12 = rand_elem();
            m.m20 = rand_elem(); m.m21 = rand_elem(); m.m22 = rand_elem();
         end
         send_matrix(m);
      end
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
rtl/core/rmq_pkg.sv
rtl/core/rmq_ctrl.sv
rtl/core/rmq_front.sv
rtl/core/rmq_sqrt.sv
rtl/core/rmq_div.sv
rtl/core/rotation_matrix_to_quaternion_top.sv
bench/rotation_matrix_to_quaternion_checker.sv
bench/rotation_matrix_to_quaternion_top_test.sv
